[hdl/hupd_pkg.sv]
// Shared constants and types for the HCI UART packet deframer.
`default_nettype none
package hupd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int HDR_MAX    = 4;
    localparam int GRP_CNT_W  = 3;
    localparam int GRP_POS_W  = 2;
    localparam int HCNT_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] TYPE_EVENT = 8'h04;
    localparam logic [BYTE_W-1:0] TYPE_ACL   = 8'h02;

    localparam logic [HCNT_W-1:0] HDR_LEN_EVT = 3'd2;
    localparam logic [HCNT_W-1:0] HDR_LEN_ACL = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HDR  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PASS = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DISC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACL = 1'd1;

    localparam logic [BYTE_W-1:0] RST_MAX_EVT = 8'd255;
    localparam logic [LEN_W-1:0]  RST_MAX_ACL = 16'd1021;

    // Result group produced by one input byte: up to four bytes of one packet.
    typedef struct packed {
        logic [GRP_CNT_W-1:0]             cnt;
        logic [HDR_MAX-1:0][BYTE_W-1:0]   bytes;
        logic                             is_acl;
        logic                             first;
        logic                             last;
    } t_group;

endpackage
`default_nettype wire

[hdl/hupd_parser.sv]
// Packet parser: phase tracking, header collection and length checks.
`default_nettype none
module hupd_parser
    import hupd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_max_evt,
    input  wire logic [LEN_W-1:0]  i_max_acl,
    output t_group                 o_group
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_is_acl, n_is_acl;
    logic [BYTE_W-1:0]  r_hdr [HDR_MAX];
    logic [BYTE_W-1:0]  n_hdr [HDR_MAX];
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    logic [LEN_W-1:0]   r_remain, n_remain;

    always_comb begin
        logic [HCNT_W-1:0] hdr_len;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  limit;
        logic [LEN_W-1:0]  dec;

        n_phase  = r_phase;
        n_is_acl = r_is_acl;
        n_hdr    = r_hdr;
        n_hcnt   = r_hcnt;
        n_remain = r_remain;
        o_group  = '0;
        hdr_len  = r_is_acl ? HDR_LEN_ACL : HDR_LEN_EVT;
        dec      = r_remain - LEN_W'(1);
        len      = '0;
        limit    = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == TYPE_EVENT || i_byte == TYPE_ACL) begin
                        n_is_acl = (i_byte == TYPE_ACL);
                        n_hcnt   = '0;
                        n_phase  = PH_HDR;
                    end
                end
                PH_HDR: begin
                    n_hdr[r_hcnt[GRP_POS_W-1:0]] = i_byte;
                    n_hcnt = r_hcnt + HCNT_W'(1);
                    if (n_hcnt >= hdr_len) begin
                        if (r_is_acl) begin
                            len   = {n_hdr[3], n_hdr[2]};
                            limit = i_max_acl;
                        end else begin
                            len   = {{(LEN_W-BYTE_W){1'b0}}, n_hdr[1]};
                            limit = {{(LEN_W-BYTE_W){1'b0}}, i_max_evt};
                        end
                        n_remain = len;
                        if (len > limit) begin
                            // Oversized: swallow the payload silently.
                            n_phase = PH_DISC;
                        end else begin
                            o_group.cnt    = hdr_len;
                            o_group.bytes  = {n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]};
                            o_group.is_acl = r_is_acl;
                            o_group.first  = 1'b1;
                            o_group.last   = (len == '0);
                            n_phase        = (len == '0) ? PH_IDLE : PH_PASS;
                        end
                    end
                end
                PH_PASS: begin
                    n_remain       = dec;
                    o_group.cnt    = GRP_CNT_W'(1);
                    o_group.bytes  = {{(3*BYTE_W){1'b0}}, i_byte};
                    o_group.is_acl = r_is_acl;
                    o_group.first  = 1'b0;
                    o_group.last   = (dec == '0);
                    if (dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DISC: begin
                    n_remain = dec;
                    if (dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_is_acl <= 1'b0;
            r_hcnt   <= '0;
            r_remain <= '0;
            for (int k = 0; k < HDR_MAX; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_is_acl <= n_is_acl;
            r_hcnt   <= n_hcnt;
            r_remain <= n_remain;
            r_hdr    <= n_hdr;
        end
    end

    // Payload phases never sit with nothing left to move.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PASS || r_phase == PH_DISC) |-> r_remain != '0)
        else $error("payload phase with zero bytes remaining");

endmodule
`default_nettype wire

[hdl/hupd_emitter.sv]
// Result group buffer and output register: drains one byte per cycle while the output is not stalled.
`default_nettype none
module hupd_emitter
    import hupd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_group            i_group,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_out_ready,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_is_acl,
    output logic                   o_first,
    output logic                   o_last
);

    logic [GRP_CNT_W-1:0]           r_left;
    logic [GRP_POS_W-1:0]           r_pos;
    logic [HDR_MAX-1:0][BYTE_W-1:0] r_bytes;
    logic                           r_is_acl;
    logic                           r_first;
    logic                           r_last;

    logic                           r_ovalid;
    logic [BYTE_W-1:0]              r_obyte;
    logic                           r_oacl;
    logic                           r_ofirst;
    logic                           r_olast;

    logic out_free;
    logic move;

    assign out_free = !r_ovalid || i_out_ready;
    assign move     = (r_left != '0) && out_free;
    assign o_ready  = (r_left == '0) || (r_left == GRP_CNT_W'(1) && move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_group.cnt != '0) begin
                r_left <= i_group.cnt;
                r_pos  <= '0;
            end else if (move) begin
                r_left <= r_left - GRP_CNT_W'(1);
                r_pos  <= r_pos + GRP_POS_W'(1);
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_group.cnt != '0) begin
            r_bytes  <= i_group.bytes;
            r_is_acl <= i_group.is_acl;
            r_first  <= i_group.first;
            r_last   <= i_group.last;
        end
        if (move) begin
            r_obyte  <= r_bytes[r_pos];
            r_oacl   <= r_is_acl;
            r_ofirst <= r_first && (r_pos == '0);
            r_olast  <= r_last && (r_left == GRP_CNT_W'(1));
        end
    end

    assign o_valid  = r_ovalid;
    assign o_byte   = r_obyte;
    assign o_is_acl = r_oacl;
    assign o_first  = r_ofirst;
    assign o_last   = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_left != '0)
        else $error("input stalled with empty group buffer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_left} + {2'b0, r_pos}) <= (GRP_CNT_W+1)'(HDR_MAX))
        else $error("group buffer position overrun");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0 && !r_ovalid) |=> r_ovalid)
        else $error("pending byte not moved to empty output register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_group.cnt != '0) |-> o_ready)
        else $error("group produced while buffer busy");

endmodule
`default_nettype wire

[hdl/hci_uart_packet_deframer_top.sv]
// Top level of the HCI UART (H4) packet deframer.
//
// Input stream: one received UART byte per item on s_axis. While idle,
// bytes other than the event (0x04) and ACL (0x02) type markers are
// skipped. The header (2 bytes event, 4 bytes ACL) is collected and the
// length checked against the configured limit for its type.
// Output stream: header, then payload bytes of an accepted packet on m_axis.
// tuser bit 0 marks ACL data, bit 1 the first header byte; tlast marks
// the final byte of the packet. Oversized packets are dropped whole.
// Path: an accepted byte's result is registered into the group buffer,
// then into the output register that drives m_axis.
// Throughput: one byte per cycle for type, header and payload bytes
// while m_axis is ready; the byte that completes a header releases 2
// or 4 output items, and s_axis holds off while that run drains
// through the single output register.
// Stall: when m_axis_tready is low the output register and group buffer
// hold, and s_axis_tready drops once the buffer holds an undelivered byte.
// Reset (synchronous, active low): idle phase, buffers empty, limits back
// to 255 (event) and 1021 (ACL). Write limits only while the block is idle.
`default_nettype none
module hci_uart_packet_deframer_top
    import hupd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Received bytes
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [7:0]            i_s_axis_tdata,   // [7:0] rx_byte
    // Rebuilt packets
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,   // [7:0] out_byte
    output logic                       o_m_axis_tlast,   // last_of_packet
    output logic [1:0]                 o_m_axis_tuser,   // [0] packet_is_acl,
                                                         // [1] first_of_packet
    // Limit registers
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [BYTE_W-1:0] r_max_evt;
    logic [LEN_W-1:0]  r_max_acl;
    logic              accept;
    logic              ready;
    logic              out_acl;
    logic              out_first;
    t_group            group;

    // Limit registers; the event limit keeps only the low byte of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_evt <= RST_MAX_EVT;
            r_max_acl <= RST_MAX_ACL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_EVT: r_max_evt <= i_cfg_wdata[BYTE_W-1:0];
                CFG_MAX_ACL: r_max_acl <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept          = i_s_axis_tvalid && ready;
    assign o_s_axis_tready = ready;
    assign o_m_axis_tuser  = {out_first, out_acl};

    hupd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_axis_tdata),
        .i_max_evt (r_max_evt),
        .i_max_acl (r_max_acl),
        .o_group   (group)
    );

    hupd_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_group     (group),
        .o_ready     (ready),
        .o_valid     (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_is_acl    (out_acl),
        .o_first     (out_first),
        .o_last      (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
